// ===== src/rist_pkg.sv =====
// Shared types, constants and helpers for the rank indexed sparse table.
package rist_pkg;

  localparam int unsigned TYPE_COUNT   = 64;
  localparam int unsigned HANDLE_WIDTH = 32;
  localparam int unsigned MASK_W       = 64;
  localparam int unsigned LANE_W       = 8;
  localparam int unsigned LANES        = MASK_W / LANE_W;
  localparam int unsigned LANE_CNT_W   = $clog2(LANE_W + 1);
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned SLOT_IDX_W   = $clog2(TYPE_COUNT);
  localparam int unsigned PADDR_W      = 4;

  localparam logic [MASK_W-1:0] TYPE_MASK =
    (TYPE_COUNT >= MASK_W) ? {MASK_W{1'b1}} : ((MASK_W'(1) << TYPE_COUNT) - MASK_W'(1));

  typedef enum logic [0:0] {
    REG_MEMBER_MASK = 1'b0
  } reg_idx_e;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NULL       = 2'd1,
    ST_NOT_MEMBER = 2'd2,
    ST_EMPTY      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RANK,
    S_SUM,
    S_MEM,
    S_DONE
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [5:0]  type_index;
    logic [31:0] handle_in;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [31:0]        handle_out;
    logic [COUNT_W-1:0] slot;
    logic [COUNT_W-1:0] member_count;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic rank;
    logic sum;
    logic mem;
    logic load;
  } ctrl_cmd_t;

  typedef logic [HANDLE_WIDTH-1:0] handle_t;

  function automatic logic [LANE_CNT_W-1:0] popcount_lane(input logic [LANE_W-1:0] v);
    logic [LANE_CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < LANE_W; i++) begin
      n = n + LANE_CNT_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== src/rank_indexed_sparse_table.sv =====
// Top level of the rank indexed sparse table.
// Each item steps through capture, rank, sum and table access to the output register;
// the next item is accepted only after the previous one is loaded into that register.
// A waiting result does not block the next accept; it holds back only the next load.
// Reset: mask cleared, all table slots read as null, no result pending.
// A mask write clears all slots in the same cycle.
module rank_indexed_sparse_table
  import rist_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [MASK_W-1:0]   pwdata,
  output logic [MASK_W-1:0]   prdata,
  output logic                pready
);

  ctrl_cmd_t         cmd;
  logic [MASK_W-1:0] mask;
  logic              clear;

  rist_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mask_o  (mask),
    .clear_o (clear)
  );

  rist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  rist_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_item_i  (in_item_i),
    .mask_i     (mask),
    .clear_i    (clear),
    .out_item_o (out_item_o)
  );

endmodule

// ===== src/rist_regs.sv =====
// APB register block holding the membership mask.
module rist_regs
  import rist_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [MASK_W-1:0]   pwdata,
  output logic [MASK_W-1:0]   prdata,
  output logic                pready,
  output logic [MASK_W-1:0]   mask_o,
  output logic                clear_o
);

  logic [MASK_W-1:0] mask_q, mask_d;
  logic              wr_mask;

  assign pready  = 1'b1;
  assign wr_mask = psel && penable && pwrite && (reg_idx_e'(paddr[3]) == REG_MEMBER_MASK);
  assign mask_d  = wr_mask ? pwdata : mask_q;
  assign clear_o = wr_mask;
  assign mask_o  = mask_q;
  assign prdata  = (reg_idx_e'(paddr[3]) == REG_MEMBER_MASK) ? mask_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

endmodule

// ===== src/rist_ctrl.sv =====
// Sequencer: steps one item through rank, sum, table access and output load.
module rist_ctrl
  import rist_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_RANK;
        end
      end
      S_RANK: begin
        cmd_o.rank = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_MEM;
      end
      S_MEM: begin
        cmd_o.mem = 1'b1;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/rist_dp.sv =====
// Datapath: lane popcounts, rank sum, handle memory and output register.
module rist_dp
  import rist_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  input  in_item_t          in_item_i,
  input  logic [MASK_W-1:0] mask_i,
  input  logic              clear_i,
  output out_item_t         out_item_o
);

  in_item_t              item_q;
  logic [LANE_CNT_W-1:0] rank_cnt_q [LANES];
  logic [LANE_CNT_W-1:0] tot_cnt_q  [LANES];
  logic                  found_q;
  logic [COUNT_W-1:0]    slot_q, count_q;
  logic [COUNT_W-1:0]    slot_d, count_d;
  status_e               status_q, status_d;
  handle_t               rd_data_q;
  logic                  rd_valid_q;
  out_item_t             out_q;

  handle_t               mem [TYPE_COUNT];
  logic [TYPE_COUNT-1:0] valid_q;

  logic [MASK_W-1:0]     members, below;
  logic [SLOT_IDX_W-1:0] addr;
  handle_t               handle;

  assign members = mask_i & TYPE_MASK;
  assign below   = (MASK_W'(1) << item_q.type_index) - MASK_W'(1);
  assign addr    = slot_q[SLOT_IDX_W-1:0];
  assign handle  = handle_t'(item_q.handle_in);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= in_item_i;
    end
    if (cmd_i.rank) begin
      for (int k = 0; k < LANES; k++) begin
        rank_cnt_q[k] <= popcount_lane(members[k*LANE_W +: LANE_W] & below[k*LANE_W +: LANE_W]);
        tot_cnt_q[k]  <= popcount_lane(members[k*LANE_W +: LANE_W]);
      end
      found_q <= members[item_q.type_index];
    end
    if (cmd_i.sum) begin
      slot_q  <= slot_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    slot_d  = '0;
    count_d = '0;
    for (int k = 0; k < LANES; k++) begin
      slot_d  = slot_d + COUNT_W'(rank_cnt_q[k]);
      count_d = count_d + COUNT_W'(tot_cnt_q[k]);
    end
  end

  always_comb begin
    priority if (handle == '0) begin
      status_d = ST_NULL;
    end else if (count_q == '0) begin
      status_d = ST_EMPTY;
    end else if (!found_q) begin
      status_d = ST_NOT_MEMBER;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem) begin
      if (item_q.opcode == OP_STORE) begin
        status_q <= status_d;
        if (status_d == ST_OK) begin
          mem[addr] <= handle;
        end
      end else begin
        status_q  <= ST_OK;
        rd_data_q <= mem[addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q    <= '0;
    end else if (cmd_i.mem) begin
      if (item_q.opcode == OP_STORE) begin
        if (status_d == ST_OK) begin
          valid_q[addr] <= 1'b1;
        end
      end else begin
        rd_valid_q <= valid_q[addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q.status       <= status_q;
      out_q.found        <= found_q;
      out_q.handle_out   <= (item_q.opcode == OP_LOOKUP && found_q && rd_valid_q)
                            ? 32'(rd_data_q) : '0;
      out_q.slot         <= slot_q;
      out_q.member_count <= count_q;
    end
  end

  assign out_item_o = out_q;

endmodule

// ===== src/rist_check.sv =====
// Port-level assertions for the rank indexed sparse table, bound to the top level.
module rist_check
  import rist_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled item dropped");

  a_nonmember_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.handle_out == '0)
    else $error("non-member item carries a handle");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.found |-> out_item_o.slot < out_item_o.member_count)
    else $error("member slot not below member count");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while previous item in flight");

endmodule

bind rank_indexed_sparse_table rist_check u_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
